FILE: rtl/harq_feedback_gap_queue_macros.svh
// assertion macros shared by the harq feedback gap queue rtl
`ifndef HARQ_FEEDBACK_GAP_QUEUE_MACROS_SVH
`define HARQ_FEEDBACK_GAP_QUEUE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HFGQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a condition in the next
`define HFGQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/hfgq_pkg.sv
// shared types, constants and helpers of the harq feedback gap queue
package hfgq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W = 32;
  localparam int GAP_W  = 4;
  localparam int KEY_W  = 20;
  localparam int CFG_AW = 3;

  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  ONE_C   = CNT_W'(1);
  localparam logic [NRES_W-1:0] MAX_C   = NRES_W'(MAX_RESULTS);

  localparam logic [GAP_W-1:0] MIN_GAP_RST = 4'd2;

  // item modes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_OCC = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_MIN_GAP = 1'b0;

  typedef enum logic {
    CMP_ELIG,
    CMP_MATCH
  } cmp_op_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] slot_number;
    logic [15:0] sender_id;
    logic [3:0]  process_id;
    logic [23:0] dest_id;
    logic [2:0]  bwp_index;
    logic        ack_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_sender_id;
    logic [3:0]  out_process_id;
    logic [23:0] out_dest_id;
    logic [2:0]  out_bwp_index;
    logic        ack_out;
    logic        last;
    logic        dropped;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [15:0]       sender_id;
    logic [3:0]        process_id;
    logic [23:0]       dest_id;
    logic [2:0]        bwp_index;
    logic              ack;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    cmp_op_e           op;
    logic [SLOT_W-1:0] lhs;
    logic [SLOT_W-1:0] rhs;
    logic [GAP_W-1:0]  gap;
  } cmp_req_t;

  function automatic logic [KEY_W-1:0] entry_key(entry_t e);
    return {e.process_id, e.sender_id};
  endfunction

  function automatic entry_t item_to_entry(in_item_t it);
    entry_t e;
    e.slot       = it.slot_number;
    e.sender_id  = it.sender_id;
    e.process_id = it.process_id;
    e.dest_id    = it.dest_id;
    e.bwp_index  = it.bwp_index;
    e.ack        = it.ack_in;
    return e;
  endfunction

  function automatic out_item_t make_out(entry_t e, logic last, logic dropped);
    out_item_t o;
    o.out_sender_id  = e.sender_id;
    o.out_process_id = e.process_id;
    o.out_dest_id    = e.dest_id;
    o.out_bwp_index  = e.bwp_index;
    o.ack_out        = e.ack;
    o.last           = last;
    o.dropped        = dropped;
    return o;
  endfunction

endpackage

FILE: rtl/hfgq_cmp.sv
// shared compare unit: slot eligibility test or sender/process key match
module hfgq_cmp (
  input  hfgq_pkg::cmp_req_t req_i,
  output logic               hit_o
);
  import hfgq_pkg::*;

  logic [SLOT_W:0] due;

  // slot plus gap at one extra bit so it never wraps
  assign due = {1'b0, req_i.rhs} + {{(SLOT_W + 1 - GAP_W){1'b0}}, req_i.gap};

  always_comb begin
    unique case (req_i.op)
      CMP_ELIG:  hit_o = ({1'b0, req_i.lhs} >= due);
      CMP_MATCH: hit_o = (req_i.lhs == req_i.rhs);
      default:   hit_o = 1'b0;
    endcase
  end

endmodule

FILE: rtl/hfgq_store.sv
// entry memory: one write port, two registered read ports
module hfgq_store (
  input  logic                       clk_i,
  input  hfgq_pkg::mem_wr_t          wr_i,
  input  logic [hfgq_pkg::IDX_W-1:0] raddr_a_i,
  input  logic [hfgq_pkg::IDX_W-1:0] raddr_b_i,
  output hfgq_pkg::entry_t           rdata_a_o,
  output hfgq_pkg::entry_t           rdata_b_o
);
  import hfgq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/harq_feedback_gap_queue.sv
// harq feedback gap queue top level: sequencer, config register, output register
// enqueue: taken in the idle state; a full queue moves to a drop state that waits on out stall
// occasion: after accept, a read and a slot check state per queued entry on one comparator
// survivor scan: an ineligible entry is skipped; an eligible one is read and its key latched,
// then each later ineligible entry is skipped and each later eligible one key-compared,
// then a put state if it survives; flush and compaction follow; out stalls hold put and flush
// async active-low reset empties the queue and sets min_gap_slots to 2
`include "harq_feedback_gap_queue_macros.svh"

module harq_feedback_gap_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hfgq_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hfgq_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hfgq_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hfgq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EL_RD   = 4'd1;
  localparam logic [3:0] S_EL_CHK  = 4'd2;
  localparam logic [3:0] S_SV_RD   = 4'd3;
  localparam logic [3:0] S_SV_KEY  = 4'd4;
  localparam logic [3:0] S_DUP_RD  = 4'd5;
  localparam logic [3:0] S_DUP_CHK = 4'd6;
  localparam logic [3:0] S_SV_PUT  = 4'd7;
  localparam logic [3:0] S_FLUSH   = 4'd8;
  localparam logic [3:0] S_CP_RD   = 4'd9;
  localparam logic [3:0] S_CP_WR   = 4'd10;
  localparam logic [3:0] S_DROP    = 4'd11;

  logic [3:0]             state_q, state_d;
  logic [CNT_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]       j_q, j_d;
  logic [CNT_W-1:0]       keep_q, keep_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [NRES_W-1:0]      n_q, n_d;
  logic [QUEUE_DEPTH-1:0] elig_q, elig_d;
  logic                   pend_valid_q, pend_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic [GAP_W-1:0]       min_gap_q;

  in_item_t  item_q, item_d;
  entry_t    cur_q, cur_d;
  entry_t    pend_q, pend_d;
  out_item_t out_q, out_d;

  logic     out_load;
  logic     out_free;
  logic     enq_store;
  mem_wr_t  wr;
  entry_t   rdata_a;
  entry_t   rdata_b;
  cmp_req_t cmp_req;
  logic     cmp_hit;

  hfgq_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .raddr_a_i (i_q[IDX_W-1:0]),
    .raddr_b_i (j_q[IDX_W-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  hfgq_cmp u_cmp (
    .req_i (cmp_req),
    .hit_o (cmp_hit)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    keep_d       = keep_q;
    count_d      = count_q;
    n_d          = n_q;
    elig_d       = elig_q;
    pend_valid_d = pend_valid_q;
    item_d       = item_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    out_load     = 1'b0;
    out_d        = out_q;
    in_ready_o   = 1'b0;
    wr.we        = 1'b0;
    wr.addr      = keep_q[IDX_W-1:0];
    wr.data      = rdata_a;
    cmp_req.op   = CMP_ELIG;
    cmp_req.lhs  = item_q.slot_number;
    cmp_req.rhs  = rdata_a.slot;
    cmp_req.gap  = min_gap_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.mode == MODE_ENQ) begin
            if (count_q < DEPTH_C) begin
              wr.we   = 1'b1;
              wr.addr = count_q[IDX_W-1:0];
              wr.data = item_to_entry(in_data_i);
              count_d = count_q + ONE_C;
            end else begin
              state_d = S_DROP;
            end
          end else if (count_q != '0) begin
            i_d     = '0;
            n_d     = '0;
            elig_d  = '0;
            state_d = S_EL_RD;
          end
        end
      end
      S_EL_RD: begin
        state_d = S_EL_CHK;
      end
      S_EL_CHK: begin
        elig_d[i_q[IDX_W-1:0]] = cmp_hit;
        if (i_q + ONE_C == count_q) begin
          i_d     = '0;
          state_d = S_SV_RD;
        end else begin
          i_d     = i_q + ONE_C;
          state_d = S_EL_RD;
        end
      end
      S_SV_RD: begin
        if (i_q == count_q) begin
          state_d = S_FLUSH;
        end else if (!elig_q[i_q[IDX_W-1:0]]) begin
          i_d = i_q + ONE_C;
        end else begin
          j_d     = i_q + ONE_C;
          state_d = S_SV_KEY;
        end
      end
      S_SV_KEY: begin
        cur_d   = rdata_a;
        state_d = S_DUP_RD;
      end
      S_DUP_RD: begin
        if (j_q == count_q) begin
          state_d = S_SV_PUT;
        end else if (!elig_q[j_q[IDX_W-1:0]]) begin
          j_d = j_q + ONE_C;
        end else begin
          state_d = S_DUP_CHK;
        end
      end
      S_DUP_CHK: begin
        cmp_req.op  = CMP_MATCH;
        cmp_req.lhs = {{(SLOT_W - KEY_W){1'b0}}, entry_key(rdata_b)};
        cmp_req.rhs = {{(SLOT_W - KEY_W){1'b0}}, entry_key(cur_q)};
        // a later eligible entry for the same pair supersedes this one
        if (cmp_hit) begin
          i_d     = i_q + ONE_C;
          state_d = S_SV_RD;
        end else begin
          j_d     = j_q + ONE_C;
          state_d = S_DUP_RD;
        end
      end
      S_SV_PUT: begin
        if (n_q >= MAX_C) begin
          i_d     = i_q + ONE_C;
          state_d = S_SV_RD;
        end else if (!pend_valid_q || out_free) begin
          // survivor held back one step so the last one can be marked
          if (pend_valid_q) begin
            out_load = 1'b1;
            out_d    = make_out(pend_q, 1'b0, 1'b0);
          end
          pend_d       = cur_q;
          pend_valid_d = 1'b1;
          n_d          = n_q + NRES_W'(1);
          i_d          = i_q + ONE_C;
          state_d      = S_SV_RD;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_load = 1'b1;
            out_d    = make_out(pend_q, 1'b1, 1'b0);
          end
          pend_valid_d = 1'b0;
          i_d          = '0;
          keep_d       = '0;
          state_d      = S_CP_RD;
        end
      end
      S_CP_RD: begin
        if (i_q == count_q) begin
          count_d = keep_q;
          state_d = S_IDLE;
        end else if (elig_q[i_q[IDX_W-1:0]]) begin
          i_d = i_q + ONE_C;
        end else begin
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        wr.we   = 1'b1;
        wr.addr = keep_q[IDX_W-1:0];
        wr.data = rdata_a;
        keep_d  = keep_q + ONE_C;
        i_d     = i_q + ONE_C;
        state_d = S_CP_RD;
      end
      S_DROP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = make_out(item_to_entry(item_q), 1'b1, 1'b1);
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      keep_q       <= '0;
      count_q      <= '0;
      n_q          <= '0;
      elig_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      keep_q       <= keep_d;
      count_q      <= count_d;
      n_q          <= n_d;
      elig_q       <= elig_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= MIN_GAP_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_GAP) begin
      min_gap_q <= pwdata[GAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_GAP: prdata = {{(32 - GAP_W){1'b0}}, min_gap_q};
      default:     prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // enqueue transfer that finds room in the queue
  assign enq_store = in_valid_i && in_ready_o && in_data_i.mode == MODE_ENQ &&
                     count_q != DEPTH_C;

  `HFGQ_ASSERT(a_count_bound, count_q <= DEPTH_C, "entry count exceeds queue depth")
  `HFGQ_ASSERT_NEXT(a_enq_count, enq_store, count_q == $past(count_q) + ONE_C, "enqueue lost")
  `HFGQ_ASSERT(a_idle_no_pend, state_q == S_IDLE |-> !pend_valid_q, "survivor left pending")
  `HFGQ_ASSERT(a_drop_full, out_load && out_d.dropped |-> count_q == DEPTH_C, "drop with room")

endmodule

FILE: tb/harq_feedback_gap_queue_tb.sv
// self-checking testbench for the harq feedback gap queue with a built-in predictor
module harq_feedback_gap_queue_tb;
  import hfgq_pkg::*;

  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AT      = 24;

  // predicts the feedback the queue emits and checks each output transfer against it
  class feedback_scoreboard;
    entry_t          pending_entries[$];
    out_item_t       expected_fb[$];
    logic [GAP_W-1:0] min_gap;
    int              errors;

    function new();
      min_gap = MIN_GAP_RST;
      errors  = 0;
    endfunction

    function int pending();
      return expected_fb.size();
    endfunction

    function out_item_t to_result(entry_t e, logic last, logic dropped);
      out_item_t r;
      r.out_sender_id  = e.sender_id;
      r.out_process_id = e.process_id;
      r.out_dest_id    = e.dest_id;
      r.out_bwp_index  = e.bwp_index;
      r.ack_out        = e.ack;
      r.last           = last;
      r.dropped        = dropped;
      return r;
    endfunction

    function void note_item(in_item_t it);
      entry_t    e;
      entry_t    kept[$];
      int        picks[$];
      bit        elig[];
      bit        later;
      logic [32:0] now;
      e.slot       = it.slot_number;
      e.sender_id  = it.sender_id;
      e.process_id = it.process_id;
      e.dest_id    = it.dest_id;
      e.bwp_index  = it.bwp_index;
      e.ack        = it.ack_in;
      if (it.mode == MODE_ENQ) begin
        if (pending_entries.size() >= QUEUE_DEPTH)
          expected_fb = {expected_fb, to_result(e, 1'b1, 1'b1)};
        else
          pending_entries = {pending_entries, e};
        return;
      end
      now  = {1'b0, it.slot_number};
      elig = new[pending_entries.size()];
      // slot plus gap at 33 bits so it never wraps
      foreach (pending_entries[i])
        elig[i] = now >= ({1'b0, pending_entries[i].slot} + 33'(min_gap));
      foreach (pending_entries[i]) begin
        if (elig[i]) begin
          later = 1'b0;
          for (int j = i + 1; j < pending_entries.size(); j++)
            if (elig[j] && pending_entries[j].sender_id == pending_entries[i].sender_id &&
                pending_entries[j].process_id == pending_entries[i].process_id)
              later = 1'b1;
          if (!later && picks.size() < MAX_RESULTS)
            picks = {picks, i};
        end
      end
      foreach (picks[k])
        expected_fb = {expected_fb,
                       to_result(pending_entries[picks[k]], k == picks.size() - 1, 1'b0)};
      foreach (pending_entries[i])
        if (!elig[i])
          kept = {kept, pending_entries[i]};
      pending_entries = kept;
    endfunction

    function void cmp_field(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_fb.size() == 0) begin
        $error("output transfer with no feedback expected: 0x%0h", got);
        errors++;
        return;
      end
      exp = expected_fb[0];
      expected_fb.delete(0);
      cmp_field("out_sender_id", 32'(exp.out_sender_id), 32'(got.out_sender_id));
      cmp_field("out_process_id", 32'(exp.out_process_id), 32'(got.out_process_id));
      cmp_field("out_dest_id", 32'(exp.out_dest_id), 32'(got.out_dest_id));
      cmp_field("out_bwp_index", 32'(exp.out_bwp_index), 32'(got.out_bwp_index));
      cmp_field("ack_out", 32'(exp.ack_out), 32'(got.ack_out));
      cmp_field("last", 32'(exp.last), 32'(got.last));
      cmp_field("dropped", 32'(exp.dropped), 32'(got.dropped));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b1;
  out_item_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [CFG_AW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  feedback_scoreboard sb = new();
  int                 sent_cnt = 0;
  bit                 tx_burst = 1'b0;

  harq_feedback_gap_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // random entry, ids biased toward a few values so (sender, process) pairs repeat
  function automatic in_item_t rand_item(logic mode, logic [31:0] slot);
    in_item_t it;
    it.mode        = mode;
    it.slot_number = slot;
    it.sender_id   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
    it.process_id  = ($urandom_range(0, 1) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
    it.dest_id     = 24'($urandom);
    it.bwp_index   = 3'($urandom);
    it.ack_in      = 1'($urandom);
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (sent_cnt % 16 == 0)
      tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    sent_cnt++;
  endtask

  // register writes only once the queue has gone quiet
  task automatic set_min_gap(logic [GAP_W-1:0] gap);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MIN_GAP, 2'b00};
    pwdata  <= 32'(gap);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.min_gap = gap;
  endtask

  task automatic run_directed();
    in_item_t   it;
    logic [3:0] idx;
    send_item(rand_item(MODE_OCC, '0));  // occasion on an empty queue
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      idx = 4'(i);
      it.mode = MODE_ENQ;
      case (i)
        8:       it.slot_number = 32'hFFFF_FFFD;
        9:       it.slot_number = 32'hFFFF_FFFE;
        10:      it.slot_number = 32'hFFFF_FFFF;
        default: it.slot_number = (i < 4) ? 32'd0 : (i < 8) ? 32'd8 : 32'd3;
      endcase
      it.sender_id  = idx[1] ? 16'hFFFF : 16'h0000;
      it.process_id = idx[2] ? 4'hF : 4'h0;
      it.dest_id    = idx[0] ? 24'hFF_FFFF : 24'h00_0000;
      it.bwp_index  = idx[3:1];
      it.ack_in     = idx[0];
      send_item(it);
    end
    // queue full: refused entry comes back marked dropped
    it = '1;
    it.mode = MODE_ENQ;
    it.slot_number = 32'd7;
    send_item(it);
    send_item(rand_item(MODE_OCC, 32'd10));
    // entries near the top of the slot range must not wrap into eligibility
    send_item(rand_item(MODE_OCC, 32'hFFFF_FFFF));
    set_min_gap(4'd0);
    send_item(rand_item(MODE_OCC, 32'hFFFF_FFFF));
  endtask

  task automatic run_random_phase(logic [GAP_W-1:0] gap, int n_items);
    logic [31:0] now_slot;
    logic [31:0] step;
    int          sel;
    set_min_gap(gap);
    case ($urandom_range(0, 3))
      0:       now_slot = $urandom_range(0, 50);
      1:       now_slot = 32'hFFFF_FF00 + $urandom_range(0, 63);
      default: now_slot = $urandom;
    endcase
    for (int k = 0; k < n_items; k++) begin
      step = $urandom_range(0, 3);
      now_slot = (now_slot > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : now_slot + step;
      sel  = $urandom_range(0, 9);
      step = $urandom_range(0, 18);
      if (sel < 6)
        send_item(rand_item(MODE_ENQ, (now_slot < step) ? 32'd0 : now_slot - step));
      else if (sel == 6)
        send_item(rand_item(MODE_ENQ, $urandom));  // stray slot, often far ahead
      else
        send_item(rand_item(MODE_OCC, now_slot));
    end
    send_item(rand_item(MODE_OCC, 32'hFFFF_FFFF));
  endtask

  initial begin : result_sink
    int gap;
    int seen;
    bit rx_burst;
    bit held;
    seen     = 0;
    rx_burst = 1'b0;
    held     = 1'b0;
    forever begin
      if (seen % 16 == 0)
        rx_burst = ($urandom_range(0, 3) == 0);
      if (!held && seen == HOLD_AT) begin
        // long back-pressure so the queue fills and stalls its input
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
      seen++;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random_phase(4'd15, 70);
    run_random_phase(4'd0, 70);
    run_random_phase(4'($urandom_range(1, 14)), 70);
    run_random_phase(4'd1, 70);
    run_random_phase(4'd0, 70);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
